FILE: src/power_iteration_eigen_2x2_assert.svh
// assertion macros for the port-level checker of the power iteration block
// no dependencies; include by bare file name
`ifndef POWER_ITERATION_EIGEN_2X2_ASSERT_SVH
`define POWER_ITERATION_EIGEN_2X2_ASSERT_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PIE_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("%m: property failed");

// same, on the house clock and reset names
`define PIE_ASSERT(lbl, prop) `PIE_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: src/pie_pkg.sv
// types, widths and codes of the power iteration eigenvalue block
// no dependencies; used by every other file of the block but the assertion header
`timescale 1ns / 1ps
`default_nettype none
package pie_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int MAT_W      = 32;  // matrix entry
  localparam int VEC_W      = 32;  // unit vector component, |v| <= 2^F
  localparam int T_W        = 34;  // product vector component, |t| <= 2^32
  localparam int E_W        = 35;  // eigenvalue estimate
  localparam int DIFF_W     = 36;
  localparam int PROD_W     = 66;  // signed product of the shared multiplier
  localparam int NRM_W      = 34;  // magnitudes during normalisation
  localparam int NORM_TOP   = 31;  // normalised magnitudes lie in [2^30, 2^31)
  localparam int SQ_W       = 63;  // sum of squares
  localparam int MAG_W      = 32;  // square root
  localparam int EPS_W      = 24;
  localparam int ITER_W     = 10;
  localparam int VAL_W      = 40;
  localparam int OUT_VEC_W  = 26;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [EPS_W-1:0]  EPS_RESET  = 24'd17;
  localparam logic [ITER_W-1:0] ITER_RESET = 10'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPSILON  = 1'b0,
    REG_MAX_ITER = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_M00, S_M01, S_M10, S_M11, S_E0, S_E1, S_TEST,
    S_NINIT, S_NSHIFT, S_SQA, S_SQB, S_SQRT, S_DIVA, S_DIVB, S_COMMIT, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_MUL_M00, OP_MUL_M01, OP_MUL_M10, OP_MUL_M11, OP_MUL_E0,
    OP_MUL_E1, OP_TEST, OP_NORM_INIT, OP_NORM_SHIFT, OP_SQ_A, OP_SQ_B,
    OP_SQRT, OP_DIV_A, OP_DIV_B, OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;  // first cycle of a multi-cycle step
    logic load;   // input transaction
    logic fin;    // final re-normalisation of v
    logic emit;   // copy result into the output register
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic more;     // passes below max_iterations
    logic conv;
    logic zero;
    logic norm_ok;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/pie_if.sv
// channel interfaces of the power iteration block: input, result, configuration
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
interface pie_in_if;
  import pie_pkg::*;
  logic valid;
  logic ready;
  logic signed [MAT_W-1:0] entry_row0_col0;
  logic signed [MAT_W-1:0] entry_row0_col1;
  logic signed [MAT_W-1:0] entry_row1_col0;
  logic signed [MAT_W-1:0] entry_row1_col1;
  modport source (output valid, entry_row0_col0, entry_row0_col1, entry_row1_col0,
                  entry_row1_col1, input ready);
  modport sink (input valid, entry_row0_col0, entry_row0_col1, entry_row1_col0,
                entry_row1_col1, output ready);
endinterface

interface pie_out_if;
  import pie_pkg::*;
  logic valid;
  logic ready;
  logic signed [VAL_W-1:0]     dominant_value;
  logic signed [OUT_VEC_W-1:0] vector_x;
  logic signed [OUT_VEC_W-1:0] vector_y;
  logic [ITER_W-1:0]           passes_done;
  logic                        converged;
  logic                        zero_vector;
  modport source (output valid, dominant_value, vector_x, vector_y, passes_done,
                  converged, zero_vector, input ready);
  modport sink (input valid, dominant_value, vector_x, vector_y, passes_done,
                converged, zero_vector, output ready);
endinterface

interface pie_cfg_if;
  import pie_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/power_iteration_eigen_2x2.sv
// top level of the 2x2 power iteration block: controller plus datapath
// depends on pie_pkg, pie_if, pie_ctrl, pie_datapath
`timescale 1ns / 1ps
`default_nettype none
// usage
// in_i takes one 2x2 signed matrix per transaction; ready is high only while
// the block is idle, so one matrix is worked on at a time.
// out_o gives one result per matrix: eigenvalue, unit vector, pass count and
// the converged and zero-vector flags. the result sits in an output register,
// so a new matrix is taken while an earlier result still waits on a stalled
// receiver; the block only holds before emitting a second result.
// cfg_i writes epsilon (index 0) and max_iterations (index 1) at any time the
// block is idle; its ready is always high.
// each pass runs the matrix and estimate multiplications and the convergence
// test, then normalises its vector with a shift, the squaring multiplications,
// the square root and the divisions; a final normalisation of v then runs
// before the result enters the output register.
// reset: asynchronous, active low; epsilon returns to 17 and max_iterations
// to 100, any matrix in flight is dropped and out valid is cleared.
module power_iteration_eigen_2x2 #(
  parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pie_in_if.sink    in_i,
  pie_out_if.source out_o,
  pie_cfg_if.sink   cfg_i
);
  import pie_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  pie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pie_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .m00_i            (in_i.entry_row0_col0),
    .m01_i            (in_i.entry_row0_col1),
    .m10_i            (in_i.entry_row1_col0),
    .m11_i            (in_i.entry_row1_col1),
    .dominant_value_o (out_o.dominant_value),
    .vector_x_o       (out_o.vector_x),
    .vector_y_o       (out_o.vector_y),
    .passes_done_o    (out_o.passes_done),
    .converged_o      (out_o.converged),
    .zero_vector_o    (out_o.zero_vector)
  );
endmodule
`default_nettype wire

FILE: src/pie_mul.sv
// shift-add signed multiplier, one multiplier bit per cycle
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
module pie_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [pie_pkg::T_W-1:0]   a_i,
  input  wire logic signed [pie_pkg::VEC_W-1:0] b_i,
  output logic                               done_o,
  output logic signed [pie_pkg::PROD_W-1:0]  res_o
);
  import pie_pkg::*;

  localparam int CNT_W = $clog2(VEC_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(VEC_W - 1);

  logic [PROD_W-1:0] ma_q, acc_q, acc_d;
  logic [VEC_W-1:0]  mb_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, busy_q, done_q;
  logic [T_W-1:0]    abs_a;
  logic [VEC_W-1:0]  abs_b;

  assign abs_a = a_i[T_W-1] ? (~a_i + 1'b1) : a_i;
  assign abs_b = b_i[VEC_W-1] ? (~b_i + 1'b1) : b_i;
  assign acc_d = acc_q + (mb_q[0] ? ma_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= PROD_W'(abs_a);
      mb_q  <= abs_b;
      acc_q <= '0;
      neg_q <= a_i[T_W-1] ^ b_i[VEC_W-1];
    end else if (busy_q) begin
      acc_q <= acc_d;
      ma_q  <= ma_q << 1;
      mb_q  <= mb_q >> 1;
      if (cnt_q == LAST) res_o <= neg_q ? $signed(~acc_d + 1'b1) : $signed(acc_d);
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

FILE: src/pie_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
module pie_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pie_pkg::SQ_W-1:0]   n_i,
  output logic                            done_o,
  output logic [pie_pkg::MAG_W-1:0]       root_o
);
  import pie_pkg::*;

  localparam int W = 2 * MAG_W;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

  logic [W-1:0]     rem_q, res_q, bit_q, trial;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= W'(n_i);
      res_q <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[MAG_W-1:0];
endmodule
`default_nettype wire

FILE: src/pie_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
module pie_div #(
  parameter int NUM_W = 55
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [NUM_W-1:0]          num_i,
  input  wire logic [pie_pkg::MAG_W-1:0] den_i,
  output logic                           done_o,
  output logic [NUM_W-1:0]               quo_o
);
  import pie_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0] num_q, quo_q;
  logic [MAG_W-1:0] den_q, rem_q;
  logic [MAG_W:0]   part;
  logic             ge;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign part = {rem_q, num_q[NUM_W-1]};
  assign ge   = part >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_q <= ge ? MAG_W'(part - {1'b0, den_q}) : part[MAG_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      num_q <= num_q << 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

FILE: src/pie_datapath.sv
// datapath: matrix, vector and estimate registers, configuration registers,
// shared multiplier, square root and divider, output register; depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
module pie_datapath #(
  parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pie_pkg::cmd_t                     cmd_i,
  output pie_pkg::sts_t                          sts_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [pie_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pie_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic signed [pie_pkg::MAT_W-1:0]  m00_i,
  input  wire logic signed [pie_pkg::MAT_W-1:0]  m01_i,
  input  wire logic signed [pie_pkg::MAT_W-1:0]  m10_i,
  input  wire logic signed [pie_pkg::MAT_W-1:0]  m11_i,
  output logic signed [pie_pkg::VAL_W-1:0]       dominant_value_o,
  output logic signed [pie_pkg::OUT_VEC_W-1:0]   vector_x_o,
  output logic signed [pie_pkg::OUT_VEC_W-1:0]   vector_y_o,
  output logic [pie_pkg::ITER_W-1:0]             passes_done_o,
  output logic                                   converged_o,
  output logic                                   zero_vector_o
);
  import pie_pkg::*;

  localparam int NUM_W = NORM_TOP + FRAC_BITS;

  logic [EPS_W-1:0]         eps_q;
  logic [ITER_W-1:0]        maxit_q, passes_q;
  logic signed [MAT_W-1:0]  m00_q, m01_q, m10_q, m11_q;
  logic signed [VEC_W-1:0]  v0_q, v1_q;
  logic signed [T_W-1:0]    t0_q, t1_q, ep_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [E_W-1:0]    e_q, prev_q;
  logic                     conv_q, zero_q, s0_q, s1_q;
  logic [NRM_W-1:0]         a_q, b_q, mx;
  logic [SQ_W-1:0]          n_q;
  logic [MAG_W-1:0]         mag_q, root;
  logic [VEC_W-1:0]         qa_q, qb_q;

  logic signed [T_W-1:0]    mul_a, src0, src1;
  logic signed [VEC_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_res;
  logic                     mul_done, sqrt_done, div_done;
  logic [NUM_W-1:0]         div_num, quo;

  logic signed [PROD_W:0]   tsum, tsh;
  logic signed [PROD_W-1:0] esh;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        adiff;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_M00: begin mul_a = T_W'(m00_q); mul_b = v0_q; end
      OP_MUL_M01: begin mul_a = T_W'(m01_q); mul_b = v1_q; end
      OP_MUL_M10: begin mul_a = T_W'(m10_q); mul_b = v0_q; end
      OP_MUL_M11: begin mul_a = T_W'(m11_q); mul_b = v1_q; end
      OP_MUL_E0:  begin mul_a = t0_q;        mul_b = v0_q; end
      OP_MUL_E1:  begin mul_a = t1_q;        mul_b = v1_q; end
      OP_SQ_A: begin
        mul_a = $signed(a_q);
        mul_b = $signed({1'b0, a_q[NORM_TOP-1:0]});
      end
      OP_SQ_B: begin
        mul_a = $signed(b_q);
        mul_b = $signed({1'b0, b_q[NORM_TOP-1:0]});
      end
      default: ;
    endcase
  end

  pie_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && (cmd_i.op == OP_MUL_M00 || cmd_i.op == OP_MUL_M01 ||
              cmd_i.op == OP_MUL_M10 || cmd_i.op == OP_MUL_M11 ||
              cmd_i.op == OP_MUL_E0 || cmd_i.op == OP_MUL_E1 ||
              cmd_i.op == OP_SQ_A || cmd_i.op == OP_SQ_B)),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pie_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && cmd_i.op == OP_SQRT),
    .n_i     (n_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign div_num = (cmd_i.op == OP_DIV_B) ? {b_q[NORM_TOP-1:0], {FRAC_BITS{1'b0}}}
                                          : {a_q[NORM_TOP-1:0], {FRAC_BITS{1'b0}}};

  pie_div #(.NUM_W(NUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && (cmd_i.op == OP_DIV_A || cmd_i.op == OP_DIV_B)),
    .num_i   (div_num),
    .den_i   (mag_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // floor shifts are arithmetic right shifts of the two's complement values
  assign tsum  = {p_q[PROD_W-1], p_q} + {mul_res[PROD_W-1], mul_res};
  assign tsh   = tsum >>> FRAC_BITS;
  assign esh   = mul_res >>> FRAC_BITS;
  assign diff  = DIFF_W'(e_q) - DIFF_W'(prev_q);
  assign adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign src0 = cmd_i.fin ? T_W'(v0_q) : t0_q;
  assign src1 = cmd_i.fin ? T_W'(v1_q) : t1_q;
  assign mx   = (a_q > b_q) ? a_q : b_q;

  always_comb begin
    sts_o.mul_done  = mul_done;
    sts_o.sqrt_done = sqrt_done;
    sts_o.div_done  = div_done;
    sts_o.more      = passes_q < maxit_q;
    sts_o.conv      = adiff < DIFF_W'(eps_q);
    sts_o.zero      = (src0 == '0) && (src1 == '0);
    sts_o.norm_ok   = (mx[NRM_W-1:NORM_TOP] == '0) && mx[NORM_TOP-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= EPS_RESET;
      maxit_q <= ITER_RESET;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_EPSILON:  eps_q   <= cfg_data_i[EPS_W-1:0];
        REG_MAX_ITER: maxit_q <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m00_q    <= m00_i;
      m01_q    <= m01_i;
      m10_q    <= m10_i;
      m11_q    <= m11_i;
      v0_q     <= VEC_W'(1) << FRAC_BITS;
      v1_q     <= '0;
      prev_q   <= '0;
      passes_q <= '0;
      conv_q   <= 1'b0;
      zero_q   <= 1'b0;
    end
    case (cmd_i.op)
      OP_MUL_M00, OP_MUL_M10: if (mul_done) p_q <= mul_res;
      OP_MUL_M01: if (mul_done) t0_q <= tsh[T_W-1:0];
      OP_MUL_M11: if (mul_done) t1_q <= tsh[T_W-1:0];
      OP_MUL_E0:  if (mul_done) ep_q <= esh[T_W-1:0];
      OP_MUL_E1:  if (mul_done) e_q <= E_W'(ep_q) + E_W'($signed(esh[T_W-1:0]));
      OP_TEST:    if (sts_o.conv) conv_q <= 1'b1;
      OP_NORM_INIT: begin
        if (sts_o.zero && !cmd_i.fin) zero_q <= 1'b1;
        s0_q <= src0[T_W-1];
        s1_q <= src1[T_W-1];
        a_q  <= src0[T_W-1] ? NRM_W'(-src0) : NRM_W'(src0);
        b_q  <= src1[T_W-1] ? NRM_W'(-src1) : NRM_W'(src1);
      end
      OP_NORM_SHIFT: begin
        if (mx[NRM_W-1:NORM_TOP] != '0) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
        end else if (!mx[NORM_TOP-1]) begin
          a_q <= a_q << 1;
          b_q <= b_q << 1;
        end
      end
      OP_SQ_A:  if (mul_done) n_q <= mul_res[SQ_W-1:0];
      OP_SQ_B:  if (mul_done) n_q <= n_q + mul_res[SQ_W-1:0];
      OP_SQRT:  if (sqrt_done) mag_q <= root;
      OP_DIV_A: if (div_done) qa_q <= quo[VEC_W-1:0];
      OP_DIV_B: if (div_done) qb_q <= quo[VEC_W-1:0];
      OP_COMMIT: begin
        v0_q <= s0_q ? $signed(~qa_q + 1'b1) : $signed(qa_q);
        v1_q <= s1_q ? $signed(~qb_q + 1'b1) : $signed(qb_q);
        if (!cmd_i.fin) begin
          prev_q   <= e_q;
          passes_q <= passes_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      dominant_value_o <= VAL_W'(prev_q);
      vector_x_o       <= v0_q[OUT_VEC_W-1:0];
      vector_y_o       <= v1_q[OUT_VEC_W-1:0];
      passes_done_o    <= passes_q;
      converged_o      <= conv_q;
      zero_vector_o    <= zero_q;
    end
  end
endmodule
`default_nettype wire

FILE: src/pie_ctrl.sv
// controller: sequences the steps of each pass and drives the handshakes
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none
module pie_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  input  wire pie_pkg::sts_t sts_i,
  output pie_pkg::cmd_t      cmd_o
);
  import pie_pkg::*;

  state_e state_q, state_d;
  logic   fin_q, fin_d, fresh_q, out_valid_q, emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign emit        = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = S_CHECK;
        fin_d   = 1'b0;
      end
      S_CHECK: begin
        if (sts_i.more) state_d = S_M00;
        else begin
          state_d = S_NINIT;
          fin_d   = 1'b1;
        end
      end
      S_M00: if (sts_i.mul_done) state_d = S_M01;
      S_M01: if (sts_i.mul_done) state_d = S_M10;
      S_M10: if (sts_i.mul_done) state_d = S_M11;
      S_M11: if (sts_i.mul_done) state_d = S_E0;
      S_E0:  if (sts_i.mul_done) state_d = S_E1;
      S_E1:  if (sts_i.mul_done) state_d = S_TEST;
      S_TEST: begin
        state_d = S_NINIT;
        if (sts_i.conv) fin_d = 1'b1;
      end
      S_NINIT: begin
        if (!sts_i.zero) state_d = S_NSHIFT;
        else if (fin_q) state_d = S_OUT;
        else fin_d = 1'b1;  // halted pass still re-normalises v
      end
      S_NSHIFT: if (sts_i.norm_ok) state_d = S_SQA;
      S_SQA:  if (sts_i.mul_done) state_d = S_SQB;
      S_SQB:  if (sts_i.mul_done) state_d = S_SQRT;
      S_SQRT: if (sts_i.sqrt_done) state_d = S_DIVA;
      S_DIVA: if (sts_i.div_done) state_d = S_DIVB;
      S_DIVB: if (sts_i.div_done) state_d = S_COMMIT;
      S_COMMIT: state_d = fin_q ? S_OUT : S_CHECK;
      S_OUT: if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.start = fresh_q;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.fin   = fin_q;
    cmd_o.emit  = emit;
    case (state_q)
      S_M00:    cmd_o.op = OP_MUL_M00;
      S_M01:    cmd_o.op = OP_MUL_M01;
      S_M10:    cmd_o.op = OP_MUL_M10;
      S_M11:    cmd_o.op = OP_MUL_M11;
      S_E0:     cmd_o.op = OP_MUL_E0;
      S_E1:     cmd_o.op = OP_MUL_E1;
      S_TEST:   cmd_o.op = OP_TEST;
      S_NINIT:  cmd_o.op = OP_NORM_INIT;
      S_NSHIFT: cmd_o.op = OP_NORM_SHIFT;
      S_SQA:    cmd_o.op = OP_SQ_A;
      S_SQB:    cmd_o.op = OP_SQ_B;
      S_SQRT:   cmd_o.op = OP_SQRT;
      S_DIVA:   cmd_o.op = OP_DIV_A;
      S_DIVB:   cmd_o.op = OP_DIV_B;
      S_COMMIT: cmd_o.op = OP_COMMIT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      fresh_q <= (state_d != state_q);
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: src/pie_checker.sv
// port-level checker for the power iteration block, bound to its top level
// depends on pie_pkg and power_iteration_eigen_2x2_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "power_iteration_eigen_2x2_assert.svh"
module pie_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire logic [pie_pkg::VAL_W-1:0]        dominant_value_i,
  input wire logic                             converged_i,
  input wire logic                             zero_vector_i
);
  import pie_pkg::*;

  // a stalled result stays put
  `PIE_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(dominant_value_i))

  // one matrix at a time: busy right after a transaction in
  `PIE_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i)

  // a run stops for one reason only
  `PIE_ASSERT(a_one_stop_reason, out_valid_i |-> !(converged_i && zero_vector_i))
endmodule

bind power_iteration_eigen_2x2 pie_checker u_pie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .dominant_value_i (out_o.dominant_value),
  .converged_i      (out_o.converged),
  .zero_vector_i    (out_o.zero_vector)
);
`default_nettype wire

FILE: dv/eigen_checker.sv
// result checker of the 2x2 power iteration block: watches the input, result and
// configuration channels, predicts each eigenvalue result and compares it
// depends on pie_pkg and the channel interfaces of pie_if
`timescale 1ns / 1ps
module eigen_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pie_in_if    in_w,
  pie_out_if   out_w,
  pie_cfg_if   cfg_w,
  output int   fail_cnt_o,
  output int   pending_cnt_o
);
  import pie_pkg::*;

  localparam int F = FRAC_BITS_DEF;

  typedef struct {
    logic [VAL_W-1:0]     value;
    logic [OUT_VEC_W-1:0] vx;
    logic [OUT_VEC_W-1:0] vy;
    logic [ITER_W-1:0]    passes;
    logic                 conv;
    logic                 zero;
  } eigen_res_t;

  eigen_res_t        eigen_q[$];
  logic [EPS_W-1:0]  eps_q;
  logic [ITER_W-1:0] iter_lim_q;

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned res, pw;
    res = 0;
    pw  = 64'd1 << 62;
    while (pw > n) pw = pw >> 2;
    while (pw != 0) begin
      if (n >= res + pw) begin
        n   = n - (res + pw);
        res = (res >> 1) + pw;
      end else begin
        res = res >> 1;
      end
      pw = pw >> 2;
    end
    return res;
  endfunction

  // scale to unit length; false on a zero vector
  function automatic bit unit_vec(input longint t0, input longint t1,
                                  output longint v0, output longint v1);
    longint unsigned a, b, m, mag, q0, q1;
    v0 = 0;
    v1 = 0;
    a = (t0 < 0) ? longint'(-t0) : t0;
    b = (t1 < 0) ? longint'(-t1) : t1;
    m = (a > b) ? a : b;
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 31)) begin
      a = a >> 1; b = b >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 30)) begin
      a = a << 1; b = b << 1; m = m << 1;
    end
    mag = isqrt(a * a + b * b);
    q0  = (a << F) / mag;
    q1  = (b << F) / mag;
    v0  = (t0 < 0) ? -longint'(q0) : longint'(q0);
    v1  = (t1 < 0) ? -longint'(q1) : longint'(q1);
    return 1'b1;
  endfunction

  function automatic eigen_res_t predict_eigen(input logic [MAT_W-1:0] a00, a01, a10, a11,
                                               input logic [EPS_W-1:0] eps_v,
                                               input logic [ITER_W-1:0] lim);
    longint m00, m01, m10, m11, v0, v1, prev, t0, t1, e, d, n0, n1;
    longint unsigned ad;
    int unsigned passes;
    bit conv, zero;
    eigen_res_t r;
    m00 = longint'(signed'(a00));
    m01 = longint'(signed'(a01));
    m10 = longint'(signed'(a10));
    m11 = longint'(signed'(a11));
    v0 = longint'(1) <<< F;
    v1 = 0;
    prev = 0;
    passes = 0;
    conv = 1'b0;
    zero = 1'b0;
    while (passes < lim) begin
      t0 = (m00 * v0 + m01 * v1) >>> F;
      t1 = (m10 * v0 + m11 * v1) >>> F;
      // each rayleigh term is floored on its own
      e  = ((t0 * v0) >>> F) + ((t1 * v1) >>> F);
      d  = e - prev;
      ad = (d < 0) ? longint'(-d) : d;
      if (ad < eps_v) begin
        conv = 1'b1;
        break;
      end
      if (!unit_vec(t0, t1, n0, n1)) begin
        zero = 1'b1;
        break;
      end
      v0 = n0;
      v1 = n1;
      prev = e;
      passes++;
    end
    if (unit_vec(v0, v1, n0, n1)) begin
      v0 = n0;
      v1 = n1;
    end
    r.value  = prev[VAL_W-1:0];
    r.vx     = v0[OUT_VEC_W-1:0];
    r.vy     = v1[OUT_VEC_W-1:0];
    r.passes = passes[ITER_W-1:0];
    r.conv   = conv;
    r.zero   = zero;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    eigen_res_t exp_r;
    int delta;
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
      iter_lim_q <= ITER_RESET;
      eigen_q.delete();
      pending_cnt_o <= 0;
    end else begin
      delta = 0;
      if (cfg_w.valid && cfg_w.ready) begin
        case (reg_idx_e'(cfg_w.index))
          REG_EPSILON:  eps_q <= cfg_w.data[EPS_W-1:0];
          REG_MAX_ITER: iter_lim_q <= cfg_w.data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        eigen_q.push_back(predict_eigen(in_w.entry_row0_col0, in_w.entry_row0_col1,
                                        in_w.entry_row1_col0, in_w.entry_row1_col1,
                                        eps_q, iter_lim_q));
        delta++;
      end
      if (out_w.valid && out_w.ready) begin
        if (eigen_q.size() == 0) begin
          $error("result transaction with no matrix outstanding");
          fail_cnt_o++;
        end else begin
          exp_r = eigen_q.pop_front();
          delta--;
          check_field("dominant_value", exp_r.value, $unsigned(out_w.dominant_value));
          check_field("vector_x", exp_r.vx, $unsigned(out_w.vector_x));
          check_field("vector_y", exp_r.vy, $unsigned(out_w.vector_y));
          check_field("passes_done", exp_r.passes, out_w.passes_done);
          check_field("converged", exp_r.conv, out_w.converged);
          check_field("zero_vector", exp_r.zero, out_w.zero_vector);
        end
      end
      pending_cnt_o <= pending_cnt_o + delta;
    end
  end
endmodule

FILE: dv/tb.sv
// top of the power iteration testbench: clock, reset, matrix and register stimulus,
// result back-pressure and verdict
// depends on pie_pkg, pie_if, power_iteration_eigen_2x2 and eigen_checker
`timescale 1ns / 1ps
module tb;
  import pie_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_LEN   = 8000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending_cnt;
  int   idle_cnt = 0;
  int   sent_cnt = 0;
  bit   calm = 1'b0;

  pie_in_if  in_if ();
  pie_out_if out_if ();
  pie_cfg_if cfg_if ();

  power_iteration_eigen_2x2 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  eigen_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_if),
    .out_w        (out_if),
    .cfg_w        (cfg_if),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // no transaction on any channel for too long means a hang
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  task automatic send_matrix(input logic [MAT_W-1:0] a00, a01, a10, a11);
    int gap;
    in_if.valid <= 1'b1;
    in_if.entry_row0_col0 <= a00;
    in_if.entry_row0_col1 <= a01;
    in_if.entry_row1_col0 <= a10;
    in_if.entry_row1_col1 <= a11;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // registers change only with the block idle and the input channel quiet
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int eps_v, input int lim);
    write_reg(REG_EPSILON, {8'($urandom_range(0, 255)), eps_v[EPS_W-1:0]});
    write_reg(REG_MAX_ITER, {22'($urandom_range(0, 4194303)), lim[ITER_W-1:0]});
  endtask

  function automatic logic [MAT_W-1:0] rand_entry(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 8 * ONE) - 4 * ONE;
      2: return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2 * ONE) - ONE;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_random();
    int mode;
    logic [MAT_W-1:0] a00, a01, a10, a11;
    mode = $urandom_range(0, 3);
    a00 = rand_entry(mode);
    a01 = rand_entry(mode);
    a10 = rand_entry(mode);
    a11 = rand_entry(mode);
    // symmetric half of the time, which converges
    if ($urandom_range(0, 1) == 1) a10 = a01;
    send_matrix(a00, a01, a10, a11);
  endtask

  // result side: random stalls and one long hold with the sender still busy
  initial begin
    int taken, gap;
    taken = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (taken == 30) gap = HOLD_LEN;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
    end
  end

  initial begin
    int settle;
    in_if.valid <= 1'b0;
    in_if.entry_row0_col0 <= '0;
    in_if.entry_row0_col1 <= '0;
    in_if.entry_row1_col0 <= '0;
    in_if.entry_row1_col1 <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_EPSILON;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_matrix(ONE, 0, 0, ONE);
    send_matrix(3 * ONE, 0, 0, ONE);
    send_matrix(2 * ONE, ONE, ONE, 2 * ONE);

    // epsilon zero never converges: extremes, zero vector, rotation
    set_regs(0, 4);
    send_matrix(0, 0, 0, 0);
    send_matrix(0, ONE, 0, ONE);
    send_matrix(0, 0, ONE, 0);
    send_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_matrix(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_matrix(0, -ONE, ONE, 0);
    send_matrix(0, ONE, ONE, 0);
    send_matrix(1, 1, 1, 1);
    send_matrix(-1, -1, -1, -1);

    // single pass, widest epsilon
    set_regs(24'hffffff, 1);
    send_matrix(32'h7fffffff, 0, 32'h80000000, 1);
    send_matrix(ONE, 0, 0, ONE);
    send_random();

    // largest pass bound on matrices that settle fast
    set_regs(24'hffffff, 1023);
    send_matrix(ONE, 0, 0, ONE);
    send_matrix(2 * ONE, 0, 0, ONE);
    send_matrix(2 * ONE, ONE, ONE, 2 * ONE);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_regs($urandom, $urandom_range(1, 6));
        1: set_regs($urandom_range(0, 64), $urandom_range(1, 4));
        2: set_regs($urandom_range(1 << 20, 1 << 24), $urandom_range(4, 12));
        default: set_regs($urandom >> $urandom_range(0, 23), $urandom_range(1, 6));
      endcase
      for (int k = 0; k < 10; k++) begin
        calm = (ph == 5);
        send_random();
      end
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
